// ===== sv/msr_sparse_matrix_vector_product_core_assert.svh =====
// Assertion macros for the MSR sparse matrix-vector product core.
`ifndef MSR_SPARSE_MATRIX_VECTOR_PRODUCT_CORE_ASSERT_SVH
`define MSR_SPARSE_MATRIX_VECTOR_PRODUCT_CORE_ASSERT_SVH
`ifndef SYNTH
`define MSR_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("msr core: same-cycle check failed");
`define MSR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("msr core: next-cycle check failed");
`else
`define MSR_ASSERT_SAME(lbl, ante, cons)
`define MSR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== sv/msr_pkg.sv =====
// Package: types, codes and defaults shared by the MSR product core.
`default_nettype none
package msr_pkg;

  localparam int MAX_ENTRIES_DEF = 4096;
  localparam int MAX_DIM_DEF     = 1024;
  localparam int IW_W            = 13;
  localparam int CFG_W           = 13;

  localparam logic [1:0] FUNC_LOAD_ENTRY = 2'd0;
  localparam logic [1:0] FUNC_LOAD_VEC   = 2'd1;
  localparam logic [1:0] FUNC_COMPUTE    = 2'd2;
  localparam logic [1:0] FUNC_READ       = 2'd3;

  localparam logic [1:0] CFG_DIM         = 2'd0;
  localparam logic [1:0] CFG_ENTRY_COUNT = 2'd1;
  localparam logic [1:0] CFG_SYMMETRIC   = 2'd2;

  typedef struct packed {
    logic [1:0]         func;
    logic [11:0]        index;
    logic [12:0]        index_word;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [9:0]         row;
    logic signed [31:0] result_value;
    logic               saturated;
  } out_item_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD_ENTRY, OP_LOAD_VEC, OP_CMP_START, OP_DIAG_RD, OP_DIAG_MUL,
    OP_DIAG_WR, OP_ROW_INIT, OP_ROW_RD, OP_ROW_SET, OP_ROW_NEXT, OP_ENT_RD,
    OP_COL_RD, OP_ENT_MUL, OP_SYM_MUL, OP_ACC_WR, OP_ENT_NEXT, OP_RD_START,
    OP_OUT_LOAD
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic i_done;
    logic k_done;
    logic col_ok;
    logic sym;
    logic out_free;
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DIAG_CHK, S_DIAG_MUL, S_DIAG_WR, S_ROW_CHK, S_ROW_SET, S_ENT_CHK,
    S_ENT_COL, S_ENT_MUL, S_ENT_ACC, S_SYM_MUL, S_SYM_ACC, S_ENT_NEXT, S_RD_WAIT
  } ctrl_state_t;

endpackage
`default_nettype wire

// ===== sv/msr_ctrl.sv =====
// Controller: sequences loads, the compute walk and result reads.
`default_nettype none
module msr_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic [1:0]       in_func,
  output logic                  in_stall,
  input  wire msr_pkg::status_t sts,
  output msr_pkg::cmd_t         cmd
);

  msr_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= msr_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = msr_pkg::OP_NONE;
    in_stall  = (state_r != msr_pkg::S_IDLE);
    unique case (state_r)
      msr_pkg::S_IDLE: begin
        if (in_valid) begin
          unique case (in_func)
            msr_pkg::FUNC_LOAD_ENTRY: cmd.op = msr_pkg::OP_LOAD_ENTRY;
            msr_pkg::FUNC_LOAD_VEC:   cmd.op = msr_pkg::OP_LOAD_VEC;
            msr_pkg::FUNC_COMPUTE: begin
              cmd.op    = msr_pkg::OP_CMP_START;
              state_nxt = msr_pkg::S_DIAG_CHK;
            end
            msr_pkg::FUNC_READ: begin
              cmd.op    = msr_pkg::OP_RD_START;
              state_nxt = msr_pkg::S_RD_WAIT;
            end
            default: cmd.op = msr_pkg::OP_NONE;
          endcase
        end
      end
      msr_pkg::S_DIAG_CHK: begin
        if (sts.i_done) begin
          cmd.op    = msr_pkg::OP_ROW_INIT;
          state_nxt = msr_pkg::S_ROW_CHK;
        end else begin
          cmd.op    = msr_pkg::OP_DIAG_RD;
          state_nxt = msr_pkg::S_DIAG_MUL;
        end
      end
      msr_pkg::S_DIAG_MUL: begin
        cmd.op    = msr_pkg::OP_DIAG_MUL;
        state_nxt = msr_pkg::S_DIAG_WR;
      end
      msr_pkg::S_DIAG_WR: begin
        cmd.op    = msr_pkg::OP_DIAG_WR;
        state_nxt = msr_pkg::S_DIAG_CHK;
      end
      msr_pkg::S_ROW_CHK: begin
        if (sts.i_done) begin
          state_nxt = msr_pkg::S_IDLE;
        end else begin
          cmd.op    = msr_pkg::OP_ROW_RD;
          state_nxt = msr_pkg::S_ROW_SET;
        end
      end
      msr_pkg::S_ROW_SET: begin
        cmd.op    = msr_pkg::OP_ROW_SET;
        state_nxt = msr_pkg::S_ENT_CHK;
      end
      msr_pkg::S_ENT_CHK: begin
        if (sts.k_done) begin
          cmd.op    = msr_pkg::OP_ROW_NEXT;
          state_nxt = msr_pkg::S_ROW_CHK;
        end else begin
          cmd.op    = msr_pkg::OP_ENT_RD;
          state_nxt = msr_pkg::S_ENT_COL;
        end
      end
      msr_pkg::S_ENT_COL: begin
        // bad column words are skipped
        if (sts.col_ok) begin
          cmd.op    = msr_pkg::OP_COL_RD;
          state_nxt = msr_pkg::S_ENT_MUL;
        end else begin
          cmd.op    = msr_pkg::OP_ENT_NEXT;
          state_nxt = msr_pkg::S_ENT_CHK;
        end
      end
      msr_pkg::S_ENT_MUL: begin
        cmd.op    = msr_pkg::OP_ENT_MUL;
        state_nxt = msr_pkg::S_ENT_ACC;
      end
      msr_pkg::S_ENT_ACC: begin
        cmd.op    = msr_pkg::OP_ACC_WR;
        state_nxt = sts.sym ? msr_pkg::S_SYM_MUL : msr_pkg::S_ENT_NEXT;
      end
      msr_pkg::S_SYM_MUL: begin
        cmd.op    = msr_pkg::OP_SYM_MUL;
        state_nxt = msr_pkg::S_SYM_ACC;
      end
      msr_pkg::S_SYM_ACC: begin
        cmd.op    = msr_pkg::OP_ACC_WR;
        state_nxt = msr_pkg::S_ENT_NEXT;
      end
      msr_pkg::S_ENT_NEXT: begin
        cmd.op    = msr_pkg::OP_ENT_NEXT;
        state_nxt = msr_pkg::S_ENT_CHK;
      end
      msr_pkg::S_RD_WAIT: begin
        if (sts.out_free) begin
          cmd.op    = msr_pkg::OP_OUT_LOAD;
          state_nxt = msr_pkg::S_IDLE;
        end
      end
      default: state_nxt = msr_pkg::S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/msr_dp.sv =====
// Datapath: stores, config registers, walk counters, multiplier and output register.
`default_nettype none
module msr_dp #(
  parameter int MAX_ENTRIES = msr_pkg::MAX_ENTRIES_DEF,
  parameter int MAX_DIM     = msr_pkg::MAX_DIM_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire msr_pkg::cmd_t             cmd,
  output msr_pkg::status_t               sts,
  input  wire msr_pkg::in_item_t         in_data,
  input  wire logic                      cfg_valid,
  input  wire logic [1:0]                cfg_index,
  input  wire logic [msr_pkg::CFG_W-1:0] cfg_data,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output msr_pkg::out_item_t             out_data
);

  localparam int EW   = $clog2(MAX_ENTRIES);
  localparam int DW   = $clog2(MAX_DIM);
  localparam int PW_A = (EW + 1 > msr_pkg::IW_W) ? EW + 1 : msr_pkg::IW_W;
  localparam int PW   = (PW_A > DW + 1) ? PW_A : DW + 1;
  localparam logic [PW-1:0] ME_W = PW'(MAX_ENTRIES);
  localparam logic [PW-1:0] MD_W = PW'(MAX_DIM);
  localparam logic signed [63:0] ACC_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] ACC_MIN = {1'b1, {63{1'b0}}};

  // stores
  logic [msr_pkg::IW_W-1:0] iw_mem [MAX_ENTRIES];
  logic signed [31:0]       ev_mem [MAX_ENTRIES];
  logic signed [31:0]       vec_mem [MAX_DIM];
  logic signed [63:0]       acc_mem [MAX_DIM];

  logic [msr_pkg::IW_W-1:0] iw_a_q, iw_b_q;
  logic signed [31:0]       ev_q, vec_q;
  logic signed [63:0]       acc_q;

  // config
  logic [10:0] dim_r;
  logic [12:0] ec_r;
  logic        sym_r;

  // walk and result registers
  logic [PW-1:0]      i_r, k_r, hi_r, cd_r;
  logic [DW-1:0]      c_r, acc_wa_r;
  logic signed [31:0] v_r, xi_r;
  logic signed [63:0] prod_r;
  logic               p0_oob_r, p1_oob_r;
  logic [9:0]         rd_row_r;
  logic               rd_ok_r;
  logic               out_valid_r;
  msr_pkg::out_item_t out_data_r;

  logic [PW-1:0] d_w, ec_w, dim_e, ec_e, i1, idx_e, cw, cw_m1;
  logic [PW-1:0] p0, p1, lo, hi, lo_c, hi_c;
  logic [EW-1:0] iw_a_addr;
  logic [DW-1:0] vec_addr, acc_raddr;
  logic signed [31:0] ma, mb;
  logic signed [63:0] prod_nxt, sum, sat_sum;
  logic               ovf, col_ok, load_out;
  msr_pkg::out_item_t res;

  always_comb begin
    dim_e = PW'(dim_r);
    ec_e  = PW'(ec_r);
    d_w   = (dim_e > MD_W) ? MD_W : dim_e;
    ec_w  = (ec_e > ME_W) ? ME_W : ec_e;
    i1    = i_r + PW'(1);
    idx_e = PW'(in_data.index);
    cw    = PW'(iw_a_q);
    cw_m1 = cw - PW'(1);
    col_ok = (cw != '0) && (cw <= d_w);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r <= 11'd1;
      ec_r  <= 13'd2;
      sym_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        msr_pkg::CFG_DIM:         dim_r <= cfg_data[10:0];
        msr_pkg::CFG_ENTRY_COUNT: ec_r  <= cfg_data[12:0];
        msr_pkg::CFG_SYMMETRIC:   sym_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // read addresses; the accumulator address holds while nothing new is read
  always_comb begin
    iw_a_addr = (cmd.op == msr_pkg::OP_ENT_RD) ? k_r[EW-1:0] : i_r[EW-1:0];
    vec_addr  = (cmd.op == msr_pkg::OP_COL_RD) ? cw_m1[DW-1:0] : i_r[DW-1:0];
    case (cmd.op)
      msr_pkg::OP_RD_START: acc_raddr = idx_e[DW-1:0];
      msr_pkg::OP_ENT_MUL:  acc_raddr = i_r[DW-1:0];
      msr_pkg::OP_SYM_MUL:  acc_raddr = c_r;
      default:              acc_raddr = acc_wa_r;
    endcase
  end

  always_ff @(posedge clk) begin
    iw_a_q <= iw_mem[iw_a_addr];
    iw_b_q <= iw_mem[i1[EW-1:0]];
    ev_q   <= ev_mem[iw_a_addr];
    vec_q  <= vec_mem[vec_addr];
    acc_q  <= acc_mem[acc_raddr];
    if (cmd.op == msr_pkg::OP_LOAD_ENTRY && idx_e < ME_W) begin
      iw_mem[idx_e[EW-1:0]] <= in_data.index_word;
      ev_mem[idx_e[EW-1:0]] <= in_data.value;
    end
    if (cmd.op == msr_pkg::OP_LOAD_VEC && idx_e < MD_W) begin
      vec_mem[idx_e[DW-1:0]] <= in_data.value;
    end
    // diagonal pass writes the product straight over the old accumulator
    if (cmd.op == msr_pkg::OP_DIAG_WR) begin
      acc_mem[i_r[DW-1:0]] <= prod_r;
    end else if (cmd.op == msr_pkg::OP_ACC_WR) begin
      acc_mem[acc_wa_r] <= sat_sum;
    end
  end

  // multiplier operand select
  always_comb begin
    case (cmd.op)
      msr_pkg::OP_DIAG_MUL: begin
        ma = p0_oob_r ? 32'sd0 : ev_q;
        mb = vec_q;
      end
      msr_pkg::OP_SYM_MUL: begin
        ma = v_r;
        mb = xi_r;
      end
      default: begin
        ma = v_r;
        mb = vec_q;
      end
    endcase
    prod_nxt = ma * mb;
    sum      = acc_q + prod_r;
    ovf      = (acc_q[63] == prod_r[63]) && (sum[63] != acc_q[63]);
    sat_sum  = ovf ? (acc_q[63] ? ACC_MIN : ACC_MAX) : sum;
  end

  // row bounds from one-based pointers
  always_comb begin
    p0   = p0_oob_r ? '0 : PW'(iw_a_q);
    p1   = p1_oob_r ? '0 : PW'(iw_b_q);
    lo   = (p0 == '0) ? '0 : p0 - PW'(1);
    hi   = (p1 == '0) ? '0 : p1 - PW'(1);
    lo_c = (lo < d_w + PW'(1)) ? d_w + PW'(1) : lo;
    hi_c = (hi > ec_w) ? ec_w : hi;
  end

  always_ff @(posedge clk) begin
    acc_wa_r <= acc_raddr;
    p0_oob_r <= !(i_r < ME_W);
    p1_oob_r <= !(i1 < ME_W);
    case (cmd.op) inside
      msr_pkg::OP_DIAG_MUL, msr_pkg::OP_ENT_MUL, msr_pkg::OP_SYM_MUL: prod_r <= prod_nxt;
      msr_pkg::OP_ROW_SET: begin
        k_r  <= lo_c;
        hi_r <= hi_c;
        xi_r <= vec_q;
      end
      msr_pkg::OP_COL_RD: begin
        c_r <= cw_m1[DW-1:0];
        v_r <= ev_q;
      end
      msr_pkg::OP_ENT_NEXT: k_r <= k_r + PW'(1);
      msr_pkg::OP_RD_START: begin
        rd_row_r <= in_data.index[9:0];
        rd_ok_r  <= (idx_e < d_w) && (idx_e < cd_r);
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r  <= '0;
      cd_r <= '0;
    end else begin
      case (cmd.op) inside
        msr_pkg::OP_CMP_START: begin
          i_r  <= '0;
          cd_r <= d_w;
        end
        msr_pkg::OP_ROW_INIT: i_r <= '0;
        msr_pkg::OP_DIAG_WR, msr_pkg::OP_ROW_NEXT: i_r <= i1;
        default: ;
      endcase
    end
  end

  // Q32.32 back to Q16.16: floor shift, clip when bits 63..47 disagree
  always_comb begin
    res.row          = rd_row_r;
    res.result_value = '0;
    res.saturated    = 1'b0;
    if (rd_ok_r) begin
      if (acc_q[63:47] != {17{acc_q[63]}}) begin
        res.saturated    = 1'b1;
        res.result_value = acc_q[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
        res.result_value = acc_q[47:16];
      end
    end
  end

  assign load_out = (cmd.op == msr_pkg::OP_OUT_LOAD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    sts.i_done   = !(i_r < d_w);
    sts.k_done   = !(k_r < hi_r);
    sts.col_ok   = col_ok;
    sts.sym      = sym_r;
    sts.out_free = !out_valid_r || !out_stall;
  end

endmodule
`default_nettype wire

// ===== sv/msr_sparse_matrix_vector_product_core.sv =====
// Top level of the MSR sparse matrix-vector product core.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_stall   msr_pkg::in_item_t
//   out_     output     out_valid / out_stall msr_pkg::out_item_t
//   cfg_     input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// Loads are written in the cycle they are accepted; a read stalls the input until the
// output register is free, longer while out_stall holds it, and then loads its result there.
// A compute stalls the input through a diagonal pass and a walk of the off-diagonal entries
// (with a second product per entry in symmetric mode, none when its column is skipped),
// sequenced around the single accumulator read port and multiplier.
// Reset is synchronous; stores are not reset, rows outside the last compute read as zero.
`default_nettype none
`include "msr_sparse_matrix_vector_product_core_assert.svh"
module msr_sparse_matrix_vector_product_core #(
  parameter int MAX_ENTRIES = msr_pkg::MAX_ENTRIES_DEF,
  parameter int MAX_DIM     = msr_pkg::MAX_DIM_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire msr_pkg::in_item_t         in_data,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output msr_pkg::out_item_t             out_data,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [1:0]                cfg_index,
  input  wire logic [msr_pkg::CFG_W-1:0] cfg_data
);

  msr_pkg::cmd_t    cmd;
  msr_pkg::status_t sts;

  assign cfg_ready = 1'b1;

  msr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_data.func),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  msr_dp #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .MAX_DIM     (MAX_DIM)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `MSR_ASSERT_SAME(a_load_on_transfer, (cmd.op == msr_pkg::OP_LOAD_ENTRY || cmd.op == msr_pkg::OP_LOAD_VEC), (in_valid && !in_stall))
  `MSR_ASSERT_SAME(a_out_load_free, (cmd.op == msr_pkg::OP_OUT_LOAD), sts.out_free)
  `MSR_ASSERT_NEXT(a_read_busy, (in_valid && !in_stall && in_data.func == msr_pkg::FUNC_READ), in_stall)

endmodule
`default_nettype wire
